// File: rtl/triangle_blip_sample_generator_defines.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef TRIANGLE_BLIP_SAMPLE_GENERATOR_DEFINES_SVH
`define TRIANGLE_BLIP_SAMPLE_GENERATOR_DEFINES_SVH

`define TBSG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define TBSG_NEVER(name, cond, msg) \
  `TBSG_ASSERT(name, !(cond), msg)

`endif

// File: rtl/tbsg_pkg.sv
package tbsg_pkg;

  localparam int unsigned IdxW    = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PerW    = 16;
  localparam int unsigned PeakW   = 15;
  localparam int unsigned HalfW   = PerW - 1;
  localparam int unsigned SampleW = 16;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RemW    = 32;

  // quotient bits of the envelope and period dividers, and of the triangle divider
  localparam int unsigned EnvSteps = 16;
  localparam int unsigned TriSteps = 17;
  localparam int unsigned ShW      = 5;

  // register stages from the stage-0 registers to the result registers
  localparam int unsigned Latency = EnvSteps + TriSteps + 6;

  localparam logic [LenW-1:0]  BlipLengthRst = 16'd2400;
  localparam logic [PerW-1:0]  TonePeriodRst = 16'd120;
  localparam logic [PeakW-1:0] PeakLevelRst  = 15'd26000;

  // x/20 = (x>>2)/5, and q/5 = (q*52429)>>18 exactly for q below 2^14
  localparam logic [15:0] AttRecip = 16'd52429;
  localparam int unsigned AttShift = 18;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  typedef enum logic [1:0] {
    RegBlipLength = 2'd0,
    RegTonePeriod = 2'd1,
    RegPeakLevel  = 2'd2
  } reg_idx_e;

  // envelope division and period modulo run side by side
  typedef struct packed {
    logic                oor;
    logic                mute;
    logic [RemW-1:0]     erem;
    logic [LenW-1:0]     eden;
    logic [EnvSteps-1:0] equo;
    logic [IdxW-1:0]     mrem;
  } edv_t;

  typedef struct packed {
    logic                oor;
    logic                mute;
    logic                neg;
    logic [RemW-1:0]     rem;
    logic [TriSteps-1:0] quo;
  } tdv_t;

  function automatic edv_t env_step(edv_t s, logic [ShW-1:0] sh, logic [PerW-1:0] per);
    edv_t r;
    logic [RemW-1:0] ed;
    logic [RemW-1:0] md;
    r  = s;
    ed = RemW'(s.eden) << sh;
    md = RemW'(per) << sh;
    if (s.erem >= ed) begin
      r.erem = s.erem - ed;
      r.equo = {s.equo[EnvSteps-2:0], 1'b1};
    end else begin
      r.equo = {s.equo[EnvSteps-2:0], 1'b0};
    end
    if (RemW'(s.mrem) >= md) begin
      r.mrem = s.mrem - md[IdxW-1:0];
    end
    return r;
  endfunction

  function automatic tdv_t tri_step(tdv_t s, logic [ShW-1:0] sh, logic [HalfW-1:0] half);
    tdv_t r;
    logic [RemW-1:0] hd;
    r  = s;
    hd = RemW'(half) << sh;
    if (s.rem >= hd) begin
      r.rem = s.rem - hd;
      r.quo = {s.quo[TriSteps-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[TriSteps-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/triangle_blip_sample_generator.sv
// Triangle blip sample generator: one signed 16-bit sample of an enveloped triangle
// tone per start transfer, with busy always low, so a new index is taken on every
// clock. The result shows on sample_o and index_out_of_range_o for one cycle, marked
// by sample_valid_o, in request order; the receiver cannot stall it, so it must take
// every strobed result. The index is captured at the transfer edge; after that it
// passes two bit-per-stage restoring dividers (16 stages for the envelope and the
// period modulo, 17 for the triangle scaling) plus six stages of setup, multiply and
// saturation. The user must write registers over the APB port only while no sample
// is in flight; the block itself does not enforce this.
`include "triangle_blip_sample_generator_defines.svh"

module triangle_blip_sample_generator
  import tbsg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [IdxW-1:0]           sample_index_i,
  output logic                      sample_valid_o,
  output logic signed [SampleW-1:0] sample_o,
  output logic                      index_out_of_range_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [AddrW-1:0]          paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

  // configuration registers
  logic [LenW-1:0]  blip_length_q;
  logic [PerW-1:0]  tone_period_q;
  logic [PeakW-1:0] peak_level_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic [HalfW-1:0] half;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[AddrW-1:2];
  assign half    = tone_period_q[PerW-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blip_length_q <= BlipLengthRst;
      tone_period_q <= TonePeriodRst;
      peak_level_q  <= PeakLevelRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegBlipLength: blip_length_q <= pwdata[LenW-1:0];
        RegTonePeriod: tone_period_q <= pwdata[PerW-1:0];
        RegPeakLevel:  peak_level_q  <= pwdata[PeakW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegBlipLength: prdata = DataW'(blip_length_q);
      RegTonePeriod: prdata = DataW'(tone_period_q);
      RegPeakLevel:  prdata = DataW'(peak_level_q);
      default:       prdata = '0;
    endcase
  end

  // stage 0: capture index and attack length
  logic            accept;
  logic [31:0]     att_prod;
  logic [LenW-1:0] att_raw;
  logic [LenW-1:0] att_d;
  logic            s0_vld_q;
  logic [IdxW-1:0] s0_idx_q;
  logic [LenW-1:0] s0_att_q;
  logic [LenW-1:0] s0_len_q;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign att_prod = 32'(blip_length_q[LenW-1:2]) * 32'(AttRecip);
  assign att_raw  = LenW'(att_prod >> AttShift);
  assign att_d    = (att_raw == '0) ? LenW'(1) : att_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_idx_q <= sample_index_i;
    s0_att_q <= att_d;
    s0_len_q <= blip_length_q;
  end

  // stage 1: attack or decay selection
  logic            in_att;
  logic            s1_vld_q;
  logic            s1_oor_q;
  logic            s1_mute_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [LenW-1:0] s1_sel_q;
  logic [LenW-1:0] s1_den_q;

  assign in_att = s0_idx_q < s0_att_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_oor_q  <= s0_idx_q >= s0_len_q;
    s1_mute_q <= tone_period_q < PerW'(2);
    s1_idx_q  <= s0_idx_q;
    s1_sel_q  <= in_att ? s0_idx_q : s0_len_q - s0_idx_q;
    s1_den_q  <= in_att ? s0_att_q : s0_len_q - s0_att_q;
  end

  // stage 2: envelope numerator
  logic            s2_vld_q;
  logic            s2_oor_q;
  logic            s2_mute_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [LenW-1:0] s2_den_q;
  logic [RemW-1:0] s2_num_q;
  edv_t            ediv_init;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_oor_q  <= s1_oor_q;
    s2_mute_q <= s1_mute_q;
    s2_idx_q  <= s1_idx_q;
    s2_den_q  <= s1_den_q;
    s2_num_q  <= RemW'(peak_level_q) * RemW'(s1_sel_q);
  end

  always_comb begin
    ediv_init      = '0;
    ediv_init.oor  = s2_oor_q;
    ediv_init.mute = s2_mute_q;
    ediv_init.erem = s2_num_q;
    ediv_init.eden = s2_den_q;
    ediv_init.mrem = s2_idx_q;
  end

  // envelope divider and index modulo, one quotient bit per stage
  edv_t                ediv_q [EnvSteps];
  logic [EnvSteps-1:0] ediv_vld_q;

  for (genvar k = 0; k < EnvSteps; k++) begin : g_ediv
    edv_t stage_in;
    logic vld_in;
    if (k == 0) begin : g_first
      assign stage_in = ediv_init;
      assign vld_in   = s2_vld_q;
    end else begin : g_rest
      assign stage_in = ediv_q[k-1];
      assign vld_in   = ediv_vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ediv_vld_q[k] <= 1'b0;
      end else begin
        ediv_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ediv_q[k] <= env_step(stage_in, ShW'(EnvSteps - 1 - k), tone_period_q);
    end
  end

  edv_t env_last;
  assign env_last = ediv_q[EnvSteps-1];

  // stage 4: fold the period position into the triangle ramp
  logic             s4_vld_q;
  logic             s4_oor_q;
  logic             s4_mute_q;
  logic [PeakW-1:0] s4_env_q;
  logic [IdxW-1:0]  s4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= ediv_vld_q[EnvSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s4_oor_q  <= env_last.oor;
    s4_mute_q <= env_last.mute;
    s4_env_q  <= env_last.equo[PeakW-1:0];
    s4_v_q    <= (env_last.mrem < IdxW'(half)) ? env_last.mrem
                                               : tone_period_q - env_last.mrem;
  end

  // stage 5: 2v - half as sign and magnitude
  logic signed [IdxW+1:0] tri_t;
  logic [IdxW+1:0]        tri_abs;
  logic                   s5_vld_q;
  logic                   s5_oor_q;
  logic                   s5_mute_q;
  logic                   s5_neg_q;
  logic [IdxW:0]          s5_mag_q;
  logic [PeakW-1:0]       s5_env_q;

  assign tri_t   = $signed({1'b0, s4_v_q, 1'b0}) - $signed({3'b000, half});
  assign tri_abs = tri_t[IdxW+1] ? 18'(-tri_t) : 18'(tri_t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_oor_q  <= s4_oor_q;
    s5_mute_q <= s4_mute_q;
    s5_neg_q  <= tri_t[IdxW+1];
    s5_mag_q  <= tri_abs[IdxW:0];
    s5_env_q  <= s4_env_q;
  end

  // stage 6: ramp times envelope
  logic            s6_vld_q;
  logic            s6_oor_q;
  logic            s6_mute_q;
  logic            s6_neg_q;
  logic [RemW-1:0] s6_prod_q;
  tdv_t            tdiv_init;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_oor_q  <= s5_oor_q;
    s6_mute_q <= s5_mute_q;
    s6_neg_q  <= s5_neg_q;
    s6_prod_q <= RemW'(s5_mag_q) * RemW'(s5_env_q);
  end

  always_comb begin
    tdiv_init      = '0;
    tdiv_init.oor  = s6_oor_q;
    tdiv_init.mute = s6_mute_q;
    tdiv_init.neg  = s6_neg_q;
    tdiv_init.rem  = s6_prod_q;
  end

  // magnitude divided by half, truncation toward zero via sign and magnitude
  tdv_t                tdiv_q [TriSteps];
  logic [TriSteps-1:0] tdiv_vld_q;

  for (genvar k = 0; k < TriSteps; k++) begin : g_tdiv
    tdv_t stage_in;
    logic vld_in;
    if (k == 0) begin : g_first
      assign stage_in = tdiv_init;
      assign vld_in   = s6_vld_q;
    end else begin : g_rest
      assign stage_in = tdiv_q[k-1];
      assign vld_in   = tdiv_vld_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tdiv_vld_q[k] <= 1'b0;
      end else begin
        tdiv_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      tdiv_q[k] <= tri_step(stage_in, ShW'(TriSteps - 1 - k), half);
    end
  end

  // output stage: sign, saturate, silence
  tdv_t                     tri_last;
  logic signed [TriSteps:0] tri_val;
  logic signed [SampleW-1:0] sample_d;
  logic                     out_vld_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                     out_oor_q;

  assign tri_last = tdiv_q[TriSteps-1];
  assign tri_val  = tri_last.neg ? -$signed({1'b0, tri_last.quo})
                                 : $signed({1'b0, tri_last.quo});

  always_comb begin
    if (tri_last.oor || tri_last.mute) begin
      sample_d = '0;
    end else if (tri_val > 18'(SampleMax)) begin
      sample_d = SampleMax;
    end else if (tri_val < 18'(SampleMin)) begin
      sample_d = SampleMin;
    end else begin
      sample_d = tri_val[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= tdiv_vld_q[TriSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= sample_d;
    out_oor_q    <= tri_last.oor;
  end

  assign sample_valid_o       = out_vld_q;
  assign sample_o             = out_sample_q;
  assign index_out_of_range_o = out_oor_q;

  logic env_chk;
  assign env_chk = ediv_vld_q[EnvSteps-1] && !env_last.oor;

  `TBSG_ASSERT(a_result_follows_start, out_vld_q |-> $past(s0_vld_q, Latency), "stray result")
  `TBSG_NEVER(a_envelope_range, env_chk && env_last.equo[EnvSteps-1], "envelope too large")
  `TBSG_NEVER(a_oor_silent, out_vld_q && out_oor_q && (out_sample_q != '0), "oor sample loud")

endmodule
